[design/cps_pkg.sv]
// Shared constants for the closest-point-on-segment block.
// No dependencies.
`default_nettype none
package cps_pkg;
    localparam int MARGIN_WIDTH = 12;
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 12'd25;
endpackage
`default_nettype wire

[design/cps_sqrt.sv]
// Pipelined floor integer square root, one root bit per stage.
// Carries a sideband vector and a valid bit alongside. No package use.
`default_nettype none
module cps_sqrt #(
    parameter int RB = 17,
    parameter int SW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [2*RB-1:0]   i_n,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_vld,
    output logic [RB-1:0]          o_root,
    output logic [SW-1:0]          o_side
);
    localparam int NW = 2 * RB;
    localparam int RW = RB + 2;

    logic          r_vld  [RB];
    logic [RW-1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];
    logic [NW-1:0] r_n    [RB];
    logic [SW-1:0] r_side [RB];

    for (genvar i = 0; i < RB; i++) begin : g_stage
        logic          p_vld;
        logic [RW-1:0] p_rem;
        logic [RB-1:0] p_root;
        logic [NW-1:0] p_n;
        logic [SW-1:0] p_side;
        logic [RW:0]   cur;
        logic [RW:0]   trial;
        logic          ge;
        logic [RW-1:0] n_rem;
        logic [RB-1:0] n_root;

        if (i == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = i_n;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[i-1];
            assign p_rem  = r_rem[i-1];
            assign p_root = r_root[i-1];
            assign p_n    = r_n[i-1];
            assign p_side = r_side[i-1];
        end

        always_comb begin
            cur    = {p_rem[RW-2:0], p_n[NW-1 -: 2]};
            trial  = {1'b0, p_root, 2'b01};
            ge     = (cur >= trial);
            n_rem  = ge ? RW'(cur - trial) : cur[RW-1:0];
            n_root = {p_root[RB-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
                r_n[i]    <= p_n << 2;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RB-1];
    assign o_root = r_root[RB-1];
    assign o_side = r_side[RB-1];
endmodule
`default_nettype wire

[design/cps_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband vector and a valid bit alongside. No package use.
`default_nettype none
module cps_div #(
    parameter int NB = 33,
    parameter int DB = 17,
    parameter int SW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [NB-1:0]   i_n,
    input  wire logic [DB-1:0]   i_d,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [NB-1:0]        o_q,
    output logic [SW-1:0]        o_side
);
    logic          r_vld  [NB];
    logic [DB-1:0] r_rem  [NB];
    logic [NB-1:0] r_q    [NB];
    logic [NB-1:0] r_n    [NB];
    logic [DB-1:0] r_d    [NB];
    logic [SW-1:0] r_side [NB];

    for (genvar i = 0; i < NB; i++) begin : g_stage
        logic          p_vld;
        logic [DB-1:0] p_rem;
        logic [NB-1:0] p_q;
        logic [NB-1:0] p_n;
        logic [DB-1:0] p_d;
        logic [SW-1:0] p_side;
        logic [DB:0]   cur;
        logic          ge;
        logic [DB-1:0] n_rem;

        if (i == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_q    = '0;
            assign p_n    = i_n;
            assign p_d    = i_d;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[i-1];
            assign p_rem  = r_rem[i-1];
            assign p_q    = r_q[i-1];
            assign p_n    = r_n[i-1];
            assign p_d    = r_d[i-1];
            assign p_side = r_side[i-1];
        end

        always_comb begin
            cur   = {p_rem, p_n[NB-1]};
            ge    = (cur >= {1'b0, p_d});
            n_rem = ge ? DB'(cur - {1'b0, p_d}) : cur[DB-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_q[i]    <= {p_q[NB-2:0], ge};
                r_n[i]    <= p_n << 1;
                r_d[i]    <= p_d;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NB-1];
    assign o_q    = r_q[NB-1];
    assign o_side = r_side[NB-1];

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NB-1] && (r_d[NB-1] != '0) |-> r_rem[NB-1] < r_d[NB-1])
        else $error("divider remainder not below divisor");
endmodule
`default_nettype wire

[design/closest_point_on_segment.sv]
// From input transfer to result the pipeline has one stage per root bit, per quotient
// bit of the projection divide and of the rounding divides, plus seven arithmetic
// stages. Throughput: one segment per cycle while the output is not held.
// The whole pipeline advances together; it holds while the output waits.
// Synchronous active-low reset clears valid bits and sets margin to 25.
`default_nettype none
module closest_point_on_segment #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [cps_pkg::MARGIN_WIDTH-1:0]      i_cfg_wr_data,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]         i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]         i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_end_y,
    input  wire logic signed [COORD_WIDTH-1:0]         i_ref_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_ref_y,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [COORD_WIDTH-1:0]              o_point_x,
    output logic signed [COORD_WIDTH-1:0]              o_point_y
);
    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int RB  = W + 1;
    localparam int NB  = 2 * W + 1;
    localparam int XW  = NB + 1;
    localparam int NN  = PW + 2;
    localparam int ND  = RB + 1;
    localparam int MW  = cps_pkg::MARGIN_WIDTH;
    localparam int SW1 = 2 * W + 2 * VW + 1 + NB;
    localparam int SW2 = 2 * W + 2 * VW + 1 + RB;
    localparam int SW3 = 2 * W + 2;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [MW-1:0] r_margin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= cps_pkg::MARGIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_margin <= i_cfg_wr_data;
        end
    end

    // stage 1: difference vectors
    logic                 r1_vld;
    logic signed [W-1:0]  r1_sx, r1_sy;
    logic signed [VW-1:0] r1_vx, r1_vy, r1_wx, r1_wy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_sx <= i_start_x;
            r1_sy <= i_start_y;
            r1_vx <= VW'(i_end_x) - VW'(i_start_x);
            r1_vy <= VW'(i_end_y) - VW'(i_start_y);
            r1_wx <= VW'(i_ref_x) - VW'(i_start_x);
            r1_wy <= VW'(i_ref_y) - VW'(i_start_y);
        end
    end

    // stage 2: products
    logic                 r2_vld;
    logic signed [W-1:0]  r2_sx, r2_sy;
    logic signed [VW-1:0] r2_vx, r2_vy;
    logic signed [PW-1:0] r2_vxx, r2_vyy, r2_dx, r2_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_vxx <= PW'(r1_vx * r1_vx);
            r2_vyy <= PW'(r1_vy * r1_vy);
            r2_dx  <= PW'(r1_vx * r1_wx);
            r2_dy  <= PW'(r1_vy * r1_wy);
        end
    end

    // stage 3: squared length and dot magnitude
    logic signed [PW-1:0] n3_dot;
    logic signed [PW-1:0] n3_abs;
    assign n3_dot = r2_dx + r2_dy;
    assign n3_abs = n3_dot[PW-1] ? -n3_dot : n3_dot;

    logic                 r3_vld;
    logic signed [W-1:0]  r3_sx, r3_sy;
    logic signed [VW-1:0] r3_vx, r3_vy;
    logic [PW-1:0]        r3_sq;
    logic                 r3_neg;
    logic [NB-1:0]        r3_dabs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_sq   <= r2_vxx + r2_vyy;
            r3_neg  <= n3_dot[PW-1];
            r3_dabs <= n3_abs[NB-1:0];
        end
    end

    // length
    logic           sq_vld;
    logic [RB-1:0]  sq_len;
    logic [SW1-1:0] sq_side;
    cps_sqrt #(.RB(RB), .SW(SW1)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r3_vld),
        .i_n    (r3_sq),
        .i_side ({r3_sx, r3_sy, r3_vx, r3_vy, r3_neg, r3_dabs}),
        .o_vld  (sq_vld),
        .o_root (sq_len),
        .o_side (sq_side)
    );

    logic signed [W-1:0]  s4_sx, s4_sy;
    logic signed [VW-1:0] s4_vx, s4_vy;
    logic                 s4_neg;
    logic [NB-1:0]        s4_dabs;
    assign {s4_sx, s4_sy, s4_vx, s4_vy, s4_neg, s4_dabs} = sq_side;

    // projection divide
    logic           d1_vld;
    logic [NB-1:0]  d1_q;
    logic [SW2-1:0] d1_side;
    cps_div #(.NB(NB), .DB(RB), .SW(SW2)) u_div_proj (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (sq_vld),
        .i_n    (s4_dabs),
        .i_d    (sq_len),
        .i_side ({s4_sx, s4_sy, s4_vx, s4_vy, s4_neg, sq_len}),
        .o_vld  (d1_vld),
        .o_q    (d1_q),
        .o_side (d1_side)
    );

    logic signed [W-1:0]  s5_sx, s5_sy;
    logic signed [VW-1:0] s5_vx, s5_vy;
    logic                 s5_neg;
    logic [RB-1:0]        s5_len;
    assign {s5_sx, s5_sy, s5_vx, s5_vy, s5_neg, s5_len} = d1_side;

    // stage 5: margin shift and clamp
    logic [XW-1:0] n5_m, n5_l, n5_q, n5_t, n5_hi, n5_p;
    always_comb begin
        n5_m  = XW'(r_margin);
        n5_l  = XW'(s5_len);
        n5_q  = XW'(d1_q);
        n5_t  = n5_q + n5_m;
        n5_hi = n5_l - n5_m;
        if (n5_m != '0) begin
            if ((n5_m << 1) < n5_l) begin
                if (s5_neg) begin
                    n5_p = n5_m;
                end else begin
                    n5_p = (n5_t > n5_hi) ? n5_hi : n5_t;
                end
            end else begin
                n5_p = n5_l >> 1;
            end
        end else begin
            if (s5_neg) begin
                n5_p = '0;
            end else begin
                n5_p = (n5_q > n5_l) ? n5_l : n5_q;
            end
        end
    end

    logic                 r5_vld;
    logic signed [W-1:0]  r5_sx, r5_sy;
    logic signed [VW-1:0] r5_vx, r5_vy;
    logic [RB-1:0]        r5_len, r5_proj;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= d1_vld;
        end
        if (en) begin
            r5_sx   <= s5_sx;
            r5_sy   <= s5_sy;
            r5_vx   <= s5_vx;
            r5_vy   <= s5_vy;
            r5_len  <= s5_len;
            r5_proj <= n5_p[RB-1:0];
        end
    end

    // stage 6: vector times projection
    logic                   r6_vld;
    logic signed [W-1:0]    r6_sx, r6_sy;
    logic [RB-1:0]          r6_len;
    logic signed [PW:0]     r6_prx, r6_pry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
        if (en) begin
            r6_sx  <= r5_sx;
            r6_sy  <= r5_sy;
            r6_len <= r5_len;
            r6_prx <= (PW + 1)'(r5_vx * $signed({1'b0, r5_proj}));
            r6_pry <= (PW + 1)'(r5_vy * $signed({1'b0, r5_proj}));
        end
    end

    // stage 7: rounding numerators
    logic signed [PW:0] n7_ax, n7_ay;
    assign n7_ax = r6_prx[PW] ? -r6_prx : r6_prx;
    assign n7_ay = r6_pry[PW] ? -r6_pry : r6_pry;

    logic                r7_vld;
    logic signed [W-1:0] r7_sx, r7_sy;
    logic [NN-1:0]       r7_numx, r7_numy;
    logic [ND-1:0]       r7_den;
    logic                r7_negx, r7_negy, r7_short;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
        if (en) begin
            r7_sx    <= r6_sx;
            r7_sy    <= r6_sy;
            r7_numx  <= {1'b0, n7_ax[PW-1:0], 1'b0} + NN'(r6_len);
            r7_numy  <= {1'b0, n7_ay[PW-1:0], 1'b0} + NN'(r6_len);
            r7_den   <= {r6_len, 1'b0};
            r7_negx  <= r6_prx[PW];
            r7_negy  <= r6_pry[PW];
            r7_short <= (r6_len[RB-1:1] == '0);
        end
    end

    // rounding divides
    logic           dx_vld, dy_vld;
    logic [NN-1:0]  dx_q, dy_q;
    logic [SW3-1:0] dx_side;
    logic           dy_side;
    cps_div #(.NB(NN), .DB(ND), .SW(SW3)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_n    (r7_numx),
        .i_d    (r7_den),
        .i_side ({r7_sx, r7_sy, r7_negx, r7_short}),
        .o_vld  (dx_vld),
        .o_q    (dx_q),
        .o_side (dx_side)
    );
    cps_div #(.NB(NN), .DB(ND), .SW(1)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_n    (r7_numy),
        .i_d    (r7_den),
        .i_side (r7_negy),
        .o_vld  (dy_vld),
        .o_q    (dy_q),
        .o_side (dy_side)
    );

    logic signed [W-1:0] s8_sx, s8_sy;
    logic                s8_negx, s8_short;
    assign {s8_sx, s8_sy, s8_negx, s8_short} = dx_side;

    // stage 8: output register
    logic signed [W+1:0] n8_ox, n8_oy, n8_qx, n8_qy;
    always_comb begin
        n8_qx = $signed({1'b0, dx_q[W:0]});
        n8_qy = $signed({1'b0, dy_q[W:0]});
        n8_ox = (W + 2)'(s8_sx) + (s8_negx ? -n8_qx : n8_qx);
        n8_oy = (W + 2)'(s8_sy) + (dy_side ? -n8_qy : n8_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dx_vld;
        end
        if (en) begin
            o_point_x <= s8_short ? s8_sx : n8_ox[W-1:0];
            o_point_y <= s8_short ? s8_sy : n8_oy[W-1:0];
        end
    end

    a_proj_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld |-> r5_proj <= r5_len)
        else $error("projection beyond segment length");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_vld == dy_vld)
        else $error("rounding divider lanes out of step");

    a_margin_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> r_margin == cps_pkg::MARGIN_RESET)
        else $error("margin not at reset value");
endmodule
`default_nettype wire
